>>> design/tqe_pkg.sv
`timescale 1ns / 1ps
package tqe_pkg;

	localparam int INNER_ONE   = 32767;
	localparam int IDENT_TRACE = 98300;
	localparam int SCL_MUL     = 2 * INNER_ONE;

	// widths of the fixed-point intermediates
	localparam int E_W     = 17;
	localparam int TR_W    = 19;
	localparam int Q_W     = 19;
	localparam int SCL_QW  = 16;
	localparam int ROOT_W  = 32;
	localparam int R_W     = 31;
	localparam int R_FRAC  = 30;

	typedef struct packed {
		logic signed [Q_W-1:0] qx;
		logic signed [Q_W-1:0] qy;
		logic signed [Q_W-1:0] qz;
		logic signed [Q_W-1:0] qw;
		logic                  refl;
		logic                  ident;
	} tqe_work_t;

endpackage

>>> design/tqe_frame_if.sv
`timescale 1ns / 1ps
interface tqe_frame_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] tangent_x;
	logic signed [W-1:0] tangent_y;
	logic signed [W-1:0] tangent_z;
	logic signed [W-1:0] bitangent_x;
	logic signed [W-1:0] bitangent_y;
	logic signed [W-1:0] bitangent_z;
	logic signed [W-1:0] normal_x;
	logic signed [W-1:0] normal_y;
	logic signed [W-1:0] normal_z;

	modport source (
		output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, normal_x, normal_y, normal_z,
		input  ready
	);
	modport sink (
		input  valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, normal_x, normal_y, normal_z,
		output ready
	);
endinterface

>>> design/tqe_quat_if.sv
`timescale 1ns / 1ps
interface tqe_quat_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] quat_x;
	logic signed [W-1:0] quat_y;
	logic signed [W-1:0] quat_z;
	logic signed [W-1:0] quat_w;

	modport source (
		output valid, quat_x, quat_y, quat_z, quat_w,
		input  ready
	);
	modport sink (
		input  valid, quat_x, quat_y, quat_z, quat_w,
		output ready
	);
endinterface

>>> design/tqe_div.sv
`timescale 1ns / 1ps
module tqe_div #(
	parameter int W  = 64,
	parameter int DW = 33,
	parameter int QW = 31,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic [W-1:0]  rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];
	logic [TW-1:0] tag_q [QW];

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int B = QW - 1 - k;
		logic [W-1:0]  rem_i;
		logic [W-1:0]  sub;
		logic [DW-1:0] den_i;
		logic [QW-1:0] quo_i;
		logic [TW-1:0] tag_i;

		if (k == 0) begin : g_in
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign tag_i = tag;
		end else begin : g_chain
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign quo_i = quo_q[k-1];
			assign tag_i = tag_q[k-1];
		end

		assign sub = W'(den_i) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_i;
				tag_q[k] <= tag_i;
				if (rem_i >= sub) begin
					rem_q[k] <= rem_i - sub;
					quo_q[k] <= quo_i | (QW'(1) << B);
				end else begin
					rem_q[k] <= rem_i;
					quo_q[k] <= quo_i;
				end
			end
		end
	end

	assign quo     = quo_q[QW-1];
	assign tag_out = tag_q[QW-1];
endmodule

>>> design/tqe_sqrt.sv
`timescale 1ns / 1ps
module tqe_sqrt #(
	parameter int RW = 32,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] val,
	input  logic [TW-1:0]   tag,
	output logic [RW-1:0]   root,
	output logic [TW-1:0]   tag_out
);
	localparam int VW = 2 * RW;

	logic [VW-1:0] rem_q [RW];
	logic [RW-1:0] res_q [RW];
	logic [TW-1:0] tag_q [RW];

	// one root bit per stage: keep rem = val - res^2
	for (genvar k = 0; k < RW; k++) begin : g_st
		localparam int B = RW - 1 - k;
		logic [VW-1:0] rem_i;
		logic [VW-1:0] trial;
		logic [RW-1:0] res_i;
		logic [TW-1:0] tag_i;

		if (k == 0) begin : g_in
			assign rem_i = val;
			assign res_i = '0;
			assign tag_i = tag;
		end else begin : g_chain
			assign rem_i = rem_q[k-1];
			assign res_i = res_q[k-1];
			assign tag_i = tag_q[k-1];
		end

		assign trial = (VW'(res_i) << (B + 1)) | (VW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				tag_q[k] <= tag_i;
				if (rem_i >= trial) begin
					rem_q[k] <= rem_i - trial;
					res_q[k] <= res_i | (RW'(1) << B);
				end else begin
					rem_q[k] <= rem_i;
					res_q[k] <= res_i;
				end
			end
		end
	end

	assign root    = res_q[RW-1];
	assign tag_out = tag_q[RW-1];
endmodule

>>> design/tqe_front.sv
`timescale 1ns / 1ps
module tqe_front #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	tqe_frame_if.sink          frame,
	output tqe_pkg::tqe_work_t work,
	output logic               work_valid,
	input  logic               work_room
);
	import tqe_pkg::*;

	localparam int CB   = COMPONENT_BITS;
	localparam int S    = 2**(CB-1) - 1;
	localparam int NW   = CB + 17;
	localparam int LAT  = 6;
	localparam int PW   = 2 * E_W;
	localparam int DTW  = PW + 1;
	localparam int XW   = E_W + DTW;
	localparam int DETW = XW + 2;

	logic                   en;
	logic [LAT-1:0]         vld_q;
	logic signed [CB-1:0]   vin [9];
	logic [CB-1:0]          mag [9];
	logic [NW-1:0]          num_s1 [9];
	logic                   neg_s1 [9];
	logic [NW-1:0]          hi [9];
	logic [NW-1:0]          t1 [9];
	logic [NW-1:0]          c1 [9];
	logic [NW-1:0]          qs [9];
	logic [SCL_QW-1:0]      quo_s2 [9];
	logic                   tneg_s2 [9];
	logic signed [E_W-1:0]  e3 [9];
	logic signed [E_W-1:0]  e_s3 [9];
	logic signed [PW-1:0]   m_s3 [6];
	logic signed [E_W-1:0]  e_s4 [9];
	logic signed [XW-1:0]   p_s4 [3];
	logic signed [DETW-1:0] det;
	logic signed [E_W-1:0]  e_s5 [9];
	logic                   refl_s5;
	logic signed [TR_W-1:0] tr;
	logic signed [Q_W-1:0]  x [9];
	tqe_work_t              w6;
	tqe_work_t              work_s6;

	assign en          = !vld_q[LAT-1] || work_room;
	assign frame.ready = en;
	assign work_valid  = vld_q[LAT-1];
	assign work        = work_s6;

	assign vin[0] = frame.tangent_x;
	assign vin[1] = frame.tangent_y;
	assign vin[2] = frame.tangent_z;
	assign vin[3] = frame.bitangent_x;
	assign vin[4] = frame.bitangent_y;
	assign vin[5] = frame.bitangent_z;
	assign vin[6] = frame.normal_x;
	assign vin[7] = frame.normal_y;
	assign vin[8] = frame.normal_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], frame.valid};
		end
	end

	// rescale to 32767 = 1.0, rounded
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			mag[i] = vin[i][CB-1] ? CB'(-vin[i]) : CB'(vin[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				num_s1[i] <= NW'(mag[i]) * NW'(INNER_ONE) + NW'((S - 1) / 2);
				neg_s1[i] <= vin[i][CB-1];
			end
		end
	end

	// divide by S = 2^(CB-1) - 1: fold the high part onto the low part twice
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			hi[i] = num_s1[i] >> (CB - 1);
			t1[i] = hi[i] + (num_s1[i] & NW'(S));
			c1[i] = (t1[i] & NW'(S)) + (t1[i] >> (CB - 1));
			qs[i] = hi[i] + (t1[i] >> (CB - 1)) + NW'(c1[i] >= NW'(S));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				quo_s2[i]  <= SCL_QW'(qs[i]);
				tneg_s2[i] <= neg_s1[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e3[i] = tneg_s2[i] ? -$signed(E_W'(quo_s2[i])) : $signed(E_W'(quo_s2[i]));
		end
	end

	// determinant minors
	always_ff @(posedge clk) begin
		if (en) begin
			e_s3    <= e3;
			m_s3[0] <= e3[4] * e3[8];
			m_s3[1] <= e3[5] * e3[7];
			m_s3[2] <= e3[3] * e3[8];
			m_s3[3] <= e3[5] * e3[6];
			m_s3[4] <= e3[3] * e3[7];
			m_s3[5] <= e3[4] * e3[6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4    <= e_s3;
			p_s4[0] <= e_s3[0] * (DTW'(m_s3[0]) - DTW'(m_s3[1]));
			p_s4[1] <= e_s3[1] * (DTW'(m_s3[2]) - DTW'(m_s3[3]));
			p_s4[2] <= e_s3[2] * (DTW'(m_s3[4]) - DTW'(m_s3[5]));
		end
	end

	assign det = DETW'(p_s4[0]) - DETW'(p_s4[1]) + DETW'(p_s4[2]);

	// reflected frame: flip the normal
	always_ff @(posedge clk) begin
		if (en) begin
			refl_s5 <= det[DETW-1];
			for (int i = 0; i < 9; i++) begin
				e_s5[i] <= (i >= 6 && det[DETW-1]) ? -e_s4[i] : e_s4[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			x[i] = Q_W'(e_s5[i]);
		end
		tr       = TR_W'(e_s5[0]) + TR_W'(e_s5[4]) + TR_W'(e_s5[8]);
		w6.refl  = refl_s5;
		w6.ident = tr > TR_W'(IDENT_TRACE);
		if (tr > 0) begin
			w6.qx = x[5] - x[7];
			w6.qy = x[6] - x[2];
			w6.qz = x[1] - x[3];
			w6.qw = Q_W'(INNER_ONE) + Q_W'(tr);
		end else if (x[0] > x[4] && x[0] > x[8]) begin
			w6.qx = Q_W'(INNER_ONE) + x[0] - x[4] - x[8];
			w6.qy = x[1] + x[3];
			w6.qz = x[6] + x[2];
			w6.qw = x[5] - x[7];
		end else if (x[4] > x[8]) begin
			w6.qx = x[1] + x[3];
			w6.qy = Q_W'(INNER_ONE) + x[4] - x[0] - x[8];
			w6.qz = x[5] + x[7];
			w6.qw = x[6] - x[2];
		end else begin
			w6.qx = x[6] + x[2];
			w6.qy = x[5] + x[7];
			w6.qz = Q_W'(INNER_ONE) + x[8] - x[0] - x[4];
			w6.qw = x[1] - x[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s6 <= w6;
		end
	end
endmodule

>>> design/tqe_back.sv
`timescale 1ns / 1ps
module tqe_back #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tqe_pkg::tqe_work_t work,
	input  logic               work_avail,
	output logic               work_take,
	tqe_quat_if.source         quat
);
	import tqe_pkg::*;

	function automatic logic [R_W-1:0] const_root(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] trial;
		rem = v;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = (res << (b + 1)) | (64'd1 << (2 * b));
			if (rem >= trial) begin
				rem = rem - trial;
				res = res | (64'd1 << b);
			end
		end
		return R_W'(res);
	endfunction

	localparam int     CB     = COMPONENT_BITS;
	localparam longint S      = (longint'(1) << (CB - 1)) - 1;
	localparam longint TH     = ((longint'(1) << 31) + S) / (2 * S);
	localparam logic [R_W-1:0] BIAS_C = const_root((64'd1 << 60) - 64'(TH * TH));
	localparam int     TW     = $bits(tqe_work_t);
	localparam int     NSQ    = 2 * Q_W;
	localparam int     SQV    = 2 * ROOT_W;
	localparam int     DDW    = ROOT_W + 1;
	localparam int     NUM_SH = 44;
	localparam int     LAT    = ROOT_W + R_W + 8;
	localparam int     MW     = 2 * R_W;
	localparam int     OW     = R_W + CB - 1;
	localparam logic [R_W-1:0] Q30_ONE = R_W'(64'd1 << R_FRAC);

	logic                  en;
	logic [LAT-1:0]        vld_q;
	logic signed [Q_W-1:0] qv [4];
	tqe_work_t             w_s1;
	logic [NSQ-1:0]        sq_s1 [4];
	logic [NSQ-1:0]        nsum;
	tqe_work_t             w2;
	tqe_work_t             w_s2;
	logic [NSQ-1:0]        n_s2;
	logic [ROOT_W-1:0]     root;
	tqe_work_t             w3;
	logic signed [Q_W-1:0] qv3 [4];
	logic [Q_W-1:0]        mag3 [4];
	logic [SQV-1:0]        num_s3 [4];
	logic [DDW-1:0]        den_s3;
	logic [2:0]            tag_s3 [4];
	logic [R_W-1:0]        quo4 [4];
	logic [2:0]            t4 [4];
	logic [R_W-1:0]        mag_s4 [4];
	logic                  neg_s4 [4];
	logic                  refl_s4;
	logic [MW-1:0]         prod_s5 [3];
	logic [R_W-1:0]        mag_s5 [4];
	logic                  neg_s5 [4];
	logic                  refl_s5;
	logic                  bias_s5;
	logic [R_W-1:0]        m6 [4];
	logic                  n6 [4];
	logic                  wpos;
	logic                  flip;
	logic [R_W-1:0]        mag_s6 [4];
	logic                  neg_s6 [4];
	logic [OW-1:0]         p_s7 [4];
	logic                  neg_s7 [4];
	logic [OW-1:0]         rnd [4];
	logic [CB-1:0]         sat [4];
	logic signed [CB-1:0]  o_s8 [4];

	assign en         = !vld_q[LAT-1] || quat.ready;
	assign work_take  = work_avail && en;
	assign quat.valid = vld_q[LAT-1];
	assign quat.quat_x = o_s8[0];
	assign quat.quat_y = o_s8[1];
	assign quat.quat_z = o_s8[2];
	assign quat.quat_w = o_s8[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], work_take};
		end
	end

	assign qv[0] = work.qx;
	assign qv[1] = work.qy;
	assign qv[2] = work.qz;
	assign qv[3] = work.qw;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= work;
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= NSQ'(qv[i] * qv[i]);
			end
		end
	end

	assign nsum = sq_s1[0] + sq_s1[1] + sq_s1[2] + sq_s1[3];

	always_comb begin
		w2       = w_s1;
		w2.ident = w_s1.ident || (nsum == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= nsum;
			w_s2 <= w2;
		end
	end

	tqe_sqrt #(
		.RW (ROOT_W),
		.TW (TW)
	) u_sqrt (
		.clk     (clk),
		.en      (en),
		.val     ({n_s2, {(SQV - NSQ){1'b0}}}),
		.tag     (w_s2),
		.root    (root),
		.tag_out (w3)
	);

	assign qv3[0] = w3.qx;
	assign qv3[1] = w3.qy;
	assign qv3[2] = w3.qz;
	assign qv3[3] = w3.qw;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag3[i] = qv3[i][Q_W-1] ? Q_W'(-qv3[i]) : Q_W'(qv3[i]);
		end
	end

	// rounded quotient: (2|q|*2^43 + root) / (2*root)
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= {root, 1'b0};
			for (int i = 0; i < 4; i++) begin
				num_s3[i] <= (SQV'(mag3[i]) << NUM_SH) + SQV'(root);
				tag_s3[i] <= {qv3[i][Q_W-1], w3.refl, w3.ident};
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_norm
		tqe_div #(
			.W  (SQV),
			.DW (DDW),
			.QW (R_W),
			.TW (3)
		) u_div (
			.clk     (clk),
			.en      (en),
			.num     (num_s3[i]),
			.den     (den_s3),
			.tag     (tag_s3[i]),
			.quo     (quo4[i]),
			.tag_out (t4[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_s4 <= t4[0][1];
			for (int i = 0; i < 4; i++) begin
				if (t4[0][0]) begin
					mag_s4[i] <= (i == 3) ? Q30_ONE : '0;
					neg_s4[i] <= 1'b0;
				end else begin
					mag_s4[i] <= quo4[i];
					neg_s4[i] <= t4[i][2];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			refl_s5 <= refl_s4;
			bias_s5 <= mag_s4[3] <= R_W'(TH);
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= MW'(mag_s4[i]) * MW'(BIAS_C);
			end
		end
	end

	// w bias, then force w sign to the handedness
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m6[i] = bias_s5 ? R_W'((prod_s5[i] + MW'(64'd1 << (R_FRAC - 1))) >> R_FRAC)
			                : mag_s5[i];
			n6[i] = neg_s5[i];
		end
		wpos  = !neg_s5[3] && (mag_s5[3] != '0);
		m6[3] = bias_s5 ? R_W'(TH) : mag_s5[3];
		n6[3] = bias_s5 ? !wpos : neg_s5[3];
		flip  = refl_s5 != (n6[3] && (m6[3] != '0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s6[i] <= m6[i];
				neg_s6[i] <= n6[i] ^ flip;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p_s7[i]   <= OW'(mag_s6[i]) * OW'(S);
				neg_s7[i] <= neg_s6[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rnd[i] = (p_s7[i] + OW'(64'd1 << (R_FRAC - 1))) >> R_FRAC;
			sat[i] = (rnd[i] > OW'(S)) ? CB'(S) : CB'(rnd[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				o_s8[i] <= neg_s7[i] ? -sat[i] : sat[i];
			end
		end
	end
endmodule

>>> design/tbn_to_qtangent_encoder.sv
`timescale 1ns / 1ps
// TBN to QTangent encoder.
// frame: one tangent frame per item (tangent, bitangent, normal columns,
//   signed, full scale 2^(COMPONENT_BITS-1)-1 = 1.0), valid/ready.
// quat: one unit quaternion per item, w sign = handedness, valid/ready.
// Throughput: one item per cycle while quat is not stalled, fully pipelined.
// Datapath: front end (rescale, determinant, branch select), then the
//   4-entry queue, then the back end where the 32-stage square root
//   and the 31-stage normalize divider dominate.
// When quat is stalled the back end holds; the queue then fills and the
//   front end holds and drops frame.ready, with no item lost.
// Reset clears all valid flags and the queue; data registers are not reset.
module tbn_to_qtangent_encoder #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tqe_frame_if.sink  frame,
	tqe_quat_if.source quat
);
	import tqe_pkg::*;

	localparam int FD  = 4;
	localparam int FAW = $clog2(FD);
	localparam int CW  = FAW + 1;

	tqe_work_t      work;
	tqe_work_t      fifo_q [FD];
	logic           work_valid;
	logic           room;
	logic           avail;
	logic           push;
	logic           pop;
	logic [FAW-1:0] wp_q;
	logic [FAW-1:0] rp_q;
	logic [CW-1:0]  cnt_q;

	tqe_front #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.work       (work),
		.work_valid (work_valid),
		.work_room  (room)
	);

	assign room  = cnt_q != CW'(FD);
	assign avail = cnt_q != '0;
	assign push  = work_valid && room;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FAW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	tqe_back #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (fifo_q[rp_q]),
		.work_avail (avail),
		.work_take  (pop),
		.quat       (quat)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FD))
		else $error("queue count out of range");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue count not advanced on push");

	a_w_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> quat.quat_w != '0)
		else $error("quat w is zero");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> quat.quat_x != {1'b1, {(COMPONENT_BITS - 1){1'b0}}}
			&& quat.quat_w != {1'b1, {(COMPONENT_BITS - 1){1'b0}}})
		else $error("output beyond saturation range");
endmodule
